// ===== rtl/trilinear_point_splat_grid_core_macros.svh =====
// Assertion macros for the trilinear point splat grid core
`ifndef TRILINEAR_POINT_SPLAT_GRID_CORE_MACROS_SVH
`define TRILINEAR_POINT_SPLAT_GRID_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define TPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tps assertion failed");

// Check that a condition leads to another in the next cycle
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tps assertion failed");

`endif

// ===== rtl/tps_pkg.sv =====
// Shared types, constants and helpers of the trilinear point splat grid core
package tps_pkg;

  localparam int GRID_I_DEF = 32;
  localparam int GRID_J_DEF = 32;
  localparam int GRID_K_DEF = 32;

  localparam int CFG_IDX_W = 3;
  localparam logic [31:0] INV_STEP_RST = 32'h0001_0000;

  typedef enum logic [1:0] {
    CMD_DEPOSIT = 2'd0,
    CMD_READ    = 2'd1,
    CMD_WRITE   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_INV_STEP_X = 3'd3,
    CFG_INV_STEP_Y = 3'd4,
    CFG_INV_STEP_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AXIS_X,
    MUL_AXIS_Y,
    MUL_AXIS_Z,
    MUL_BASE_K,
    MUL_BASE_J,
    MUL_WEIGHT_AB,
    MUL_WEIGHT_C
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_CHK_Z,
    ST_DECIDE,
    ST_BASE_J,
    ST_BASE_I,
    ST_CW_AB,
    ST_CW_C,
    ST_CW_WR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic       load;
    mul_sel_e   mul;
    logic       chk_en;
    logic [1:0] chk_axis;
    logic       base_set;
    logic       base_add;
    logic [2:0] corner;
    logic       mem_rd_cell;
    logic       mem_rd_corner;
    logic       mem_wr_cell;
    logic       mem_wr_sat;
    logic       clear;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic fail;
    logic clear_last;
  } dp_sts_t;

  // Per-axis weight: fraction for the upper corner, its complement for the lower one
  function automatic logic [16:0] axis_weight(input logic [15:0] frac, input logic upper);
    logic [16:0] w;
    w = upper ? {1'b0, frac} : (17'h1_0000 - {1'b0, frac});
    return w;
  endfunction

endpackage

// ===== rtl/tps_ctrl.sv =====
// Controller state machine of the trilinear point splat grid core
module tps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tps_pkg::ctrl_cmd_t cmd_o,
  input  tps_pkg::dp_sts_t   sts_i
);

  tps_pkg::state_e state_q, state_d;
  logic [2:0]      corner_q, corner_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tps_pkg::ST_CLEAR;
      corner_q    <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    corner_d   = corner_q;
    cmd_o      = '0;
    cmd_o.mul  = tps_pkg::MUL_NONE;
    cmd_o.corner = corner_q;
    in_ready_o = 1'b0;
    case (state_q)
      tps_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = tps_pkg::ST_IDLE;
        end
      end
      tps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tps_pkg::ST_DISPATCH;
        end
      end
      tps_pkg::ST_DISPATCH: begin
        case (sts_i.cmd)
          tps_pkg::CMD_DEPOSIT: begin
            cmd_o.mul = tps_pkg::MUL_AXIS_X;
            state_d   = tps_pkg::ST_MUL_Y;
          end
          tps_pkg::CMD_READ: begin
            cmd_o.mem_rd_cell = 1'b1;
            state_d           = tps_pkg::ST_FINISH;
          end
          tps_pkg::CMD_WRITE: begin
            cmd_o.mem_wr_cell = 1'b1;
            state_d           = tps_pkg::ST_FINISH;
          end
          default: begin
            state_d = tps_pkg::ST_FINISH;
          end
        endcase
      end
      tps_pkg::ST_MUL_Y: begin
        cmd_o.mul      = tps_pkg::MUL_AXIS_Y;
        cmd_o.chk_en   = 1'b1;
        cmd_o.chk_axis = 2'd0;
        state_d        = tps_pkg::ST_MUL_Z;
      end
      tps_pkg::ST_MUL_Z: begin
        cmd_o.mul      = tps_pkg::MUL_AXIS_Z;
        cmd_o.chk_en   = 1'b1;
        cmd_o.chk_axis = 2'd1;
        state_d        = tps_pkg::ST_CHK_Z;
      end
      tps_pkg::ST_CHK_Z: begin
        cmd_o.chk_en   = 1'b1;
        cmd_o.chk_axis = 2'd2;
        state_d        = tps_pkg::ST_DECIDE;
      end
      tps_pkg::ST_DECIDE: begin
        if (sts_i.fail) begin
          state_d = tps_pkg::ST_FINISH;
        end else begin
          cmd_o.mul = tps_pkg::MUL_BASE_K;
          state_d   = tps_pkg::ST_BASE_J;
        end
      end
      tps_pkg::ST_BASE_J: begin
        cmd_o.mul      = tps_pkg::MUL_BASE_J;
        cmd_o.base_set = 1'b1;
        state_d        = tps_pkg::ST_BASE_I;
      end
      tps_pkg::ST_BASE_I: begin
        cmd_o.base_add = 1'b1;
        corner_d       = 3'd0;
        state_d        = tps_pkg::ST_CW_AB;
      end
      tps_pkg::ST_CW_AB: begin
        cmd_o.mul = tps_pkg::MUL_WEIGHT_AB;
        state_d   = tps_pkg::ST_CW_C;
      end
      tps_pkg::ST_CW_C: begin
        cmd_o.mul           = tps_pkg::MUL_WEIGHT_C;
        cmd_o.mem_rd_corner = 1'b1;
        state_d             = tps_pkg::ST_CW_WR;
      end
      tps_pkg::ST_CW_WR: begin
        cmd_o.mem_wr_sat = 1'b1;
        corner_d         = corner_q + 3'd1;
        state_d          = (corner_q == 3'd7) ? tps_pkg::ST_FINISH : tps_pkg::ST_CW_AB;
      end
      tps_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = tps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tps_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tps_datapath.sv =====
// Datapath of the trilinear point splat grid core: registers, shared multiplier, grid store
module tps_datapath #(
  parameter int GridI = tps_pkg::GRID_I_DEF,
  parameter int GridJ = tps_pkg::GRID_J_DEF,
  parameter int GridK = tps_pkg::GRID_K_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i,
  input  logic [1:0]                 cmd_i,
  input  logic [31:0]                point_x_i,
  input  logic [31:0]                point_y_i,
  input  logic [31:0]                point_z_i,
  input  logic [14:0]                cell_index_i,
  input  logic [31:0]                cell_value_i,
  input  tps_pkg::ctrl_cmd_t         ctl_i,
  output tps_pkg::dp_sts_t           sts_o,
  output logic                       deposited_o,
  output logic [31:0]                read_value_o
);

  localparam int NumCells = GridI * GridJ * GridK;
  localparam int AW = $clog2(NumCells);
  localparam logic [31:0] NUM_CELLS32 = 32'(NumCells);
  localparam logic [31:0] AXIS_LIM [3] = '{32'(GridI - 1), 32'(GridJ - 1), 32'(GridK - 1)};
  localparam logic [AW-1:0] STRIDE_J = AW'(GridI);
  localparam logic [AW-1:0] STRIDE_K = AW'(GridI * GridJ);

  logic [31:0] origin_q [3];
  logic [31:0] inv_q [3];
  logic [1:0]  cmd_q;
  logic [31:0] pt_q [3];
  logic [14:0] cidx_q;
  logic [31:0] cval_q;
  logic [65:0] p_q, p_d;
  logic [AW-1:0] idx_q [3];
  logic [15:0] frac_q [3];
  logic        fail_q;
  logic [AW-1:0] base_q;
  logic [31:0] mem [NumCells];
  logic [31:0] mem_q;
  logic [AW-1:0] clr_q;
  logic        dep_q;
  logic [31:0] rval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '{32'd0, 32'd0, 32'd0};
      inv_q    <= '{tps_pkg::INV_STEP_RST, tps_pkg::INV_STEP_RST, tps_pkg::INV_STEP_RST};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tps_pkg::CFG_ORIGIN_X:   origin_q[0] <= cfg_data_i;
        tps_pkg::CFG_ORIGIN_Y:   origin_q[1] <= cfg_data_i;
        tps_pkg::CFG_ORIGIN_Z:   origin_q[2] <= cfg_data_i;
        tps_pkg::CFG_INV_STEP_X: inv_q[0]    <= cfg_data_i;
        tps_pkg::CFG_INV_STEP_Y: inv_q[1]    <= cfg_data_i;
        tps_pkg::CFG_INV_STEP_Z: inv_q[2]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      pt_q   <= '{point_x_i, point_y_i, point_z_i};
      cidx_q <= cell_index_i;
      cval_q <= cell_value_i;
    end
  end

  // Axis mapping check on the product left by the previous cycle
  logic [32:0] chk_d;
  logic [1:0]  ax;
  logic [63:0] r;
  logic        chk_ok;
  logic [AW-1:0] chk_idx;
  logic [15:0] chk_frac;

  assign ax = ctl_i.chk_axis;
  assign r  = p_q[63:0];

  always_comb begin
    chk_d    = {pt_q[ax][31], pt_q[ax]} - {origin_q[ax][31], origin_q[ax]};
    chk_ok   = 1'b1;
    chk_idx  = '0;
    chk_frac = '0;
    if (inv_q[ax] != 32'd0) begin
      if (chk_d[32]) begin
        chk_ok = 1'b0;
      end else begin
        chk_ok   = r[63:32] < AXIS_LIM[ax];
        chk_idx  = r[32 +: AW];
        chk_frac = r[31:16];
      end
    end
  end

  logic [32:0] d_ax [3];
  logic [16:0] wi, wj, wk;

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      d_ax[n] = {pt_q[n][31], pt_q[n]} - {origin_q[n][31], origin_q[n]};
    end
  end

  assign wi = tps_pkg::axis_weight(frac_q[0], ctl_i.corner[0]);
  assign wj = tps_pkg::axis_weight(frac_q[1], ctl_i.corner[1]);
  assign wk = tps_pkg::axis_weight(frac_q[2], ctl_i.corner[2]);

  logic [32:0] ma, mb;

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl_i.mul)
      tps_pkg::MUL_AXIS_X: begin
        ma = {1'b0, d_ax[0][31:0]};
        mb = {1'b0, inv_q[0]};
      end
      tps_pkg::MUL_AXIS_Y: begin
        ma = {1'b0, d_ax[1][31:0]};
        mb = {1'b0, inv_q[1]};
      end
      tps_pkg::MUL_AXIS_Z: begin
        ma = {1'b0, d_ax[2][31:0]};
        mb = {1'b0, inv_q[2]};
      end
      tps_pkg::MUL_BASE_K: begin
        ma = 33'(idx_q[2]);
        mb = 33'(STRIDE_K);
      end
      tps_pkg::MUL_BASE_J: begin
        ma = 33'(idx_q[1]);
        mb = 33'(STRIDE_J);
      end
      tps_pkg::MUL_WEIGHT_AB: begin
        ma = 33'(wi);
        mb = 33'(wj);
      end
      tps_pkg::MUL_WEIGHT_C: begin
        ma = p_q[32:0];
        mb = 33'(wk);
      end
      default: ;
    endcase
    p_d = ma * mb;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul != tps_pkg::MUL_NONE) begin
      p_q <= p_d;
    end
    if (ctl_i.chk_en) begin
      idx_q[ax]  <= chk_idx;
      frac_q[ax] <= chk_frac;
    end
    if (ctl_i.base_set) begin
      base_q <= p_q[AW-1:0];
    end else if (ctl_i.base_add) begin
      base_q <= base_q + p_q[AW-1:0] + idx_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_q <= 1'b0;
      clr_q  <= '0;
    end else begin
      if (ctl_i.load) begin
        fail_q <= 1'b0;
      end else if (ctl_i.chk_en && !chk_ok) begin
        fail_q <= 1'b1;
      end
      if (ctl_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Grid store
  logic [31:0]   cidx_w;
  logic          in_range;
  logic [AW-1:0] cell_addr, corner_addr, wr_addr, rd_addr;
  logic [32:0]   sat_sum;
  logic [31:0]   wr_data;
  logic          wr_en, rd_en;

  assign cidx_w    = 32'(cidx_q);
  assign in_range  = cidx_w < NUM_CELLS32;
  assign cell_addr = cidx_w[AW-1:0];
  assign corner_addr = base_q + (ctl_i.corner[2] ? STRIDE_K : '0)
                     + (ctl_i.corner[1] ? STRIDE_J : '0) + AW'(ctl_i.corner[0]);
  assign sat_sum   = {1'b0, mem_q} + 33'(p_q[48:32]);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = corner_addr;
    wr_data = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
    if (ctl_i.clear) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = 32'd0;
    end else if (ctl_i.mem_wr_cell) begin
      wr_en   = in_range;
      wr_addr = cell_addr;
      wr_data = cval_q;
    end else if (ctl_i.mem_wr_sat) begin
      wr_en = 1'b1;
    end
    rd_en   = ctl_i.mem_rd_cell || ctl_i.mem_rd_corner;
    rd_addr = ctl_i.mem_rd_cell ? cell_addr : corner_addr;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      dep_q  <= (cmd_q == tps_pkg::CMD_DEPOSIT) && !fail_q;
      rval_q <= ((cmd_q == tps_pkg::CMD_READ) && in_range) ? mem_q : 32'd0;
    end
  end

  assign sts_o.cmd        = tps_pkg::cmd_e'(cmd_q);
  assign sts_o.fail       = fail_q;
  assign sts_o.clear_last = clr_q == AW'(NumCells - 1);
  assign deposited_o      = dep_q;
  assign read_value_o     = rval_q;

endmodule

// ===== rtl/trilinear_point_splat_grid_core.sv =====
// Top level of the trilinear point splat grid core
//
//  channel   direction  fields
//  s_axis    in         tuser: cmd; tdata: point_x/y/z, cell_index, cell_value
//  m_axis    out        tdata: deposited, read_value
//  cfg       in         cfg_index_i, cfg_data_i
//
// After reset the grid is zeroed one cell a cycle while s_axis_tready stays low; cfg
// writes are taken at any time. A deposit runs three axis products, range decision,
// base address, then for each corner the weight products, the corner read and the
// saturating write, through the one shared 33x33 multiplier and the grid store. A
// rejected point goes from the range decision straight to the result; read, write
// and an unused command go there straight from dispatch. s_axis_tready rises as the
// result appears. A result held by m_axis_tready low stalls only the final step.
`include "trilinear_point_splat_grid_core_macros.svh"
module trilinear_point_splat_grid_core #(
  parameter int GridI = tps_pkg::GRID_I_DEF,
  parameter int GridJ = tps_pkg::GRID_J_DEF,
  parameter int GridK = tps_pkg::GRID_K_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [1:0]                    s_axis_tuser,   // [1:0] cmd
  // [31:0] point_x, [63:32] point_y, [95:64] point_z, [110:96] cell_index,
  // [142:111] cell_value, [143] zero
  input  logic [143:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,   // [0] deposited, [32:1] read_value
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  tps_pkg::ctrl_cmd_t ctl;
  tps_pkg::dp_sts_t   sts;
  logic               deposited;
  logic [31:0]        read_value;

  assign cfg_ready_o = 1'b1;

  tps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (ctl),
    .sts_i       (sts)
  );

  tps_datapath #(
    .GridI (GridI),
    .GridJ (GridJ),
    .GridK (GridK)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (s_axis_tuser),
    .point_x_i    (s_axis_tdata[31:0]),
    .point_y_i    (s_axis_tdata[63:32]),
    .point_z_i    (s_axis_tdata[95:64]),
    .cell_index_i (s_axis_tdata[110:96]),
    .cell_value_i (s_axis_tdata[142:111]),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .deposited_o  (deposited),
    .read_value_o (read_value)
  );

  assign m_axis_tdata = {7'd0, read_value, deposited};

  `TPS_ASSERT(a_no_accept_in_clear, ctl.clear |-> !s_axis_tready)
  `TPS_ASSERT_NEXT(a_accept_goes_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `TPS_ASSERT(a_deposit_reads_zero, (m_axis_tvalid && m_axis_tdata[0]) |-> !(|m_axis_tdata[32:1]))
  `TPS_ASSERT(a_one_mem_write, !(ctl.mem_wr_cell && ctl.mem_wr_sat))

endmodule
